// File: rtl/mctb_pkg.sv
// Shared types, codes and helpers of the countdown timer bank.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
package mctb_pkg;

	localparam int VAL_W   = 24;
	localparam int EXT_W   = 26;
	localparam int START_W = 23;
	localparam int TICK_W  = 8;
	localparam int CMD_W   = 3;
	localparam int IDX_W   = 2;
	localparam int SUB_W   = 7;
	localparam int SECS_W  = 2;
	localparam int MASK_W  = 3;
	localparam int NUM_START = 3;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	localparam logic signed [VAL_W-1:0] VAL_MAX = 24'sh7FFFFF;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 24'sh800000;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_RESET = 3'd3,
		CMD_SET   = 3'd4,
		CMD_READ  = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		OP_TICK,
		OP_START,
		OP_STOP,
		OP_LOAD_START,
		OP_LOAD_SET,
		OP_NONE
	} op_t;

	typedef enum logic [1:0] {
		PH_OFF,
		PH_RUNNING,
		PH_NEGATIVE,
		PH_STOPPED
	} phase_t;

	typedef enum logic [1:0] {
		EV_STATUS,
		EV_ELAPSED,
		EV_COUNTDOWN,
		EV_MINUTE
	} kind_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_TLOAD,
		B_SEC,
		B_MIN,
		B_STAT
	} bstate_t;

	typedef enum logic [2:0] {
		REG_START_0 = 3'd0,
		REG_START_1 = 3'd1,
		REG_START_2 = 3'd2,
		REG_SHOW_EL = 3'd3,
		REG_CD_BEEP = 3'd4,
		REG_MIN_BEEP = 3'd5
	} reg_t;

	typedef struct packed {
		op_t                     op;
		logic [IDX_W-1:0]        idx;
		logic                    idx_ok;
		logic signed [VAL_W-1:0] setv;
		logic [TICK_W-1:0]       tick;
	} qent_t;

	typedef struct packed {
		logic [NUM_START-1:0][START_W-1:0] start;
		logic [MASK_W-1:0]                 show_el;
		logic [MASK_W-1:0]                 cd_beep;
		logic [MASK_W-1:0]                 min_beep;
	} cfg_t;

	typedef struct packed {
		kind_t                   kind;
		logic [IDX_W-1:0]        timer;
		logic signed [VAL_W-1:0] value;
		phase_t                  ph;
		logic                    running;
		logic                    last;
	} evt_t;

	function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [EXT_W-1:0] a);
		logic signed [VAL_W-1:0] r;
		if (a > EXT_W'(VAL_MAX))
			r = VAL_MAX;
		else if (a < EXT_W'(VAL_MIN))
			r = VAL_MIN;
		else
			r = a[VAL_W-1:0];
		return r;
	endfunction

	// divisible by 60 = divisible by 4 and by 15; 16 = 1 mod 15, so sum the nibbles
	function automatic logic is_minute(input logic signed [EXT_W-1:0] a);
		logic [EXT_W-1:0] mag;
		logic [27:0]      mag_p;
		logic [6:0]       s;
		logic             hit;
		mag   = a[EXT_W-1] ? EXT_W'(-a) : EXT_W'(a);
		mag_p = {2'b00, mag};
		s     = '0;
		hit   = 1'b0;
		for (int k = 0; k < 7; k++)
			s = s + 7'(mag_p[4*k +: 4]);
		for (int k = 0; k < 8; k++)
			if (s == 7'(15 * k))
				hit = 1'b1;
		return hit && (mag[1:0] == 2'b00);
	endfunction

endpackage

// File: rtl/mctb_ifs.sv
// Channel interfaces of the timer bank: command beats in, event beats out.
// Depends on mctb_pkg for field widths.
`timescale 1ns / 1ps
interface mctb_cmd_if;
	logic                                     valid;
	logic                                     ready;
	logic [mctb_pkg::CMD_W-1:0]               cmd;
	logic [mctb_pkg::IDX_W-1:0]               timer_index;
	logic signed [mctb_pkg::VAL_W-1:0]        set_value;
	logic [mctb_pkg::TICK_W-1:0]              tick_10ms;
	modport source(output valid, cmd, timer_index, set_value, tick_10ms, input ready);
	modport sink(input valid, cmd, timer_index, set_value, tick_10ms, output ready);
endinterface

interface mctb_evt_if;
	logic                                     valid;
	logic                                     ready;
	logic [1:0]                               event_kind;
	logic [mctb_pkg::IDX_W-1:0]               event_timer;
	logic signed [mctb_pkg::VAL_W-1:0]        event_value;
	logic [1:0]                               timer_phase;
	logic                                     timer_running;
	logic                                     last;
	modport source(output valid, event_kind, event_timer, event_value, timer_phase,
		timer_running, last, input ready);
	modport sink(input valid, event_kind, event_timer, event_value, timer_phase,
		timer_running, last, output ready);
endinterface

// File: rtl/multi_countdown_timer_bank_unit.sv
// A non-tick command goes from idle to the status state, which loads its status beat
// into the event register once that register is free. A tick walks each timer in turn
// and steps a running one by at most three whole seconds; the executor runs one
// item at a time, a two-entry queue lets the front accept while it works.
// Reset (arst_n low) clears all timers, registers and queue, and the event valid flag.
`timescale 1ns / 1ps
module multi_countdown_timer_bank_unit #(
	parameter int TIMER_COUNT   = 3,
	parameter int ALERT_SECONDS = 60
) (
	input  logic                          clk,
	input  logic                          arst_n,
	mctb_cmd_if.sink                      cmds,
	mctb_evt_if.source                    events,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mctb_pkg::ADDR_W-1:0]   paddr,
	input  logic [mctb_pkg::DATA_W-1:0]   pwdata,
	output logic [mctb_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	mctb_pkg::cfg_t  cfg_q;
	mctb_pkg::qent_t f_data, q_rdata;
	logic            q_push, q_full, q_pop, q_valid;
	mctb_pkg::reg_t  ridx;
	logic            wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign ridx   = mctb_pkg::reg_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			case (ridx)
				mctb_pkg::REG_START_0:  cfg_q.start[0] <= pwdata[mctb_pkg::START_W-1:0];
				mctb_pkg::REG_START_1:  cfg_q.start[1] <= pwdata[mctb_pkg::START_W-1:0];
				mctb_pkg::REG_START_2:  cfg_q.start[2] <= pwdata[mctb_pkg::START_W-1:0];
				mctb_pkg::REG_SHOW_EL:  cfg_q.show_el  <= pwdata[mctb_pkg::MASK_W-1:0];
				mctb_pkg::REG_CD_BEEP:  cfg_q.cd_beep  <= pwdata[mctb_pkg::MASK_W-1:0];
				mctb_pkg::REG_MIN_BEEP: cfg_q.min_beep <= pwdata[mctb_pkg::MASK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			mctb_pkg::REG_START_0:  prdata = 32'(cfg_q.start[0]);
			mctb_pkg::REG_START_1:  prdata = 32'(cfg_q.start[1]);
			mctb_pkg::REG_START_2:  prdata = 32'(cfg_q.start[2]);
			mctb_pkg::REG_SHOW_EL:  prdata = 32'(cfg_q.show_el);
			mctb_pkg::REG_CD_BEEP:  prdata = 32'(cfg_q.cd_beep);
			mctb_pkg::REG_MIN_BEEP: prdata = 32'(cfg_q.min_beep);
			default:                prdata = '0;
		endcase
	end

	mctb_front #(.TIMER_COUNT(TIMER_COUNT)) u_front (
		.cmds   (cmds),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (f_data)
	);

	mctb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (f_data),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	mctb_back #(
		.TIMER_COUNT   (TIMER_COUNT),
		.ALERT_SECONDS (ALERT_SECONDS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.events  (events)
	);

endmodule

// File: rtl/mctb_front.sv
// Front end: takes command beats and classifies them into queue entries.
// Depends on mctb_pkg and mctb_cmd_if.
`timescale 1ns / 1ps
module mctb_front #(
	parameter int TIMER_COUNT = 3
) (
	mctb_cmd_if.sink          cmds,
	input  logic              q_full,
	output logic              q_push,
	output mctb_pkg::qent_t   q_data
);

	assign cmds.ready = !q_full;
	assign q_push     = cmds.valid && !q_full;

	always_comb begin
		q_data.idx    = cmds.timer_index;
		q_data.idx_ok = 32'(cmds.timer_index) < TIMER_COUNT;
		q_data.setv   = cmds.set_value;
		q_data.tick   = cmds.tick_10ms;
		case (cmds.cmd)
			mctb_pkg::CMD_TICK:  q_data.op = mctb_pkg::OP_TICK;
			mctb_pkg::CMD_START: q_data.op = mctb_pkg::OP_START;
			mctb_pkg::CMD_STOP:  q_data.op = mctb_pkg::OP_STOP;
			mctb_pkg::CMD_RESET: q_data.op = mctb_pkg::OP_LOAD_START;
			mctb_pkg::CMD_SET:   q_data.op = mctb_pkg::OP_LOAD_SET;
			default:             q_data.op = mctb_pkg::OP_NONE;
		endcase
	end

endmodule

// File: rtl/mctb_queue.sv
// Two-entry queue between front end and executor.
// Depends on mctb_pkg for the entry type.
`timescale 1ns / 1ps
module mctb_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mctb_pkg::qent_t wdata,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output mctb_pkg::qent_t rdata
);

	localparam int DEPTH = 2;

	mctb_pkg::qent_t mem_q [DEPTH];
	logic            wr_q;
	logic            rd_q;
	logic [1:0]      cnt_q;

	assign full  = cnt_q == 2'(DEPTH);
	assign valid = cnt_q != 2'd0;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// File: rtl/mctb_back.sv
// Executor: holds the timer state, applies commands, walks ticks second by
// second and drives the event register. Depends on mctb_pkg and mctb_evt_if.
`timescale 1ns / 1ps
module mctb_back #(
	parameter int TIMER_COUNT   = 3,
	parameter int ALERT_SECONDS = 60
) (
	input  logic            clk,
	input  logic            arst_n,
	input  mctb_pkg::cfg_t  cfg,
	input  logic            q_valid,
	input  mctb_pkg::qent_t q_data,
	output logic            q_pop,
	mctb_evt_if.source      events
);

	localparam int TIDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
	localparam logic [TIDX_W-1:0] LAST_T = TIDX_W'(TIMER_COUNT - 1);
	localparam logic signed [mctb_pkg::EXT_W-1:0] ALERT_X = mctb_pkg::EXT_W'(ALERT_SECONDS);
	localparam int VW = mctb_pkg::VAL_W;
	localparam int XW = mctb_pkg::EXT_W;

	logic signed [VW-1:0]          val_q [TIMER_COUNT];
	logic signed [VW-1:0]          val_d [TIMER_COUNT];
	logic [mctb_pkg::SUB_W-1:0]    sub_q [TIMER_COUNT];
	logic [mctb_pkg::SUB_W-1:0]    sub_d [TIMER_COUNT];
	mctb_pkg::phase_t              ph_q  [TIMER_COUNT];
	mctb_pkg::phase_t              ph_d  [TIMER_COUNT];
	logic [TIMER_COUNT-1:0]        run_q, run_d;

	mctb_pkg::bstate_t             state_q, state_d;
	logic [TIDX_W-1:0]             t_q, t_d;
	logic [mctb_pkg::SECS_W-1:0]   secs_q, secs_d;
	logic signed [XW-1:0]          ann_q, ann_d;
	logic                          min_q, min_d;
	mctb_pkg::evt_t                evt_q, evt_d;
	logic                          ov_q;
	logic                          ld;
	logic                          out_free;

	// per-second datapath for timer t_q
	logic [mctb_pkg::IDX_W-1:0]    tsel;
	logic signed [XW-1:0]          cst, cv, nv, nval, ann_c;
	logic                          up, brk, el_ev;
	mctb_pkg::phase_t              ph_n;
	logic [8:0]                    total;
	logic [mctb_pkg::SECS_W-1:0]   secs_c;
	logic [8:0]                    rem;
	logic [TIDX_W-1:0]             t_next;
	mctb_pkg::bstate_t             s_next;

	// command datapath
	logic [TIDX_W-1:0]             ci;
	logic signed [XW-1:0]          cval;
	logic                          cst_nz;

	assign out_free = !ov_q || events.ready;

	always_comb begin
		tsel  = mctb_pkg::IDX_W'(t_q);
		cst   = $signed({3'b000, cfg.start[tsel]});
		up    = cfg.start[tsel] == '0;
		cv    = $signed({{2{val_q[t_q][VW-1]}}, val_q[t_q]});
		brk   = up ? (val_q[t_q] == mctb_pkg::VAL_MAX) : (val_q[t_q] == mctb_pkg::VAL_MIN);
		nv    = (up ? cv : cst - cv) + XW'(1);
		ph_n  = ph_q[t_q];
		el_ev = 1'b0;
		if (ph_q[t_q] == mctb_pkg::PH_RUNNING) begin
			if (!up && nv >= cst) begin
				ph_n  = mctb_pkg::PH_NEGATIVE;
				el_ev = 1'b1;
			end
		end else if (ph_q[t_q] == mctb_pkg::PH_NEGATIVE) begin
			if (nv >= cst + ALERT_X)
				ph_n = mctb_pkg::PH_STOPPED;
		end
		nval  = up ? nv : cst - nv;
		ann_c = cfg.show_el[tsel] ? cst - nval : nval;

		total = 9'(sub_q[t_q]) + 9'(q_data.tick);
		if (total >= 9'd300)
			secs_c = 2'd3;
		else if (total >= 9'd200)
			secs_c = 2'd2;
		else if (total >= 9'd100)
			secs_c = 2'd1;
		else
			secs_c = 2'd0;
		rem = total - 9'(secs_c) * 9'd100;

		t_next = (t_q == LAST_T) ? t_q : t_q + TIDX_W'(1);
		s_next = (t_q == LAST_T) ? mctb_pkg::B_STAT : mctb_pkg::B_TLOAD;

		ci     = TIDX_W'(q_data.idx);
		cval   = $signed({{2{val_q[ci][VW-1]}}, val_q[ci]});
		cst_nz = cfg.start[q_data.idx] != '0;
	end

	always_comb begin
		state_d = state_q;
		val_d   = val_q;
		sub_d   = sub_q;
		ph_d    = ph_q;
		run_d   = run_q;
		t_d     = t_q;
		secs_d  = secs_q;
		ann_d   = ann_q;
		min_d   = min_q;
		q_pop   = 1'b0;
		ld      = 1'b0;
		evt_d   = '0;
		evt_d.timer = tsel;

		case (state_q)
			mctb_pkg::B_IDLE: begin
				if (q_valid) begin
					if (q_data.op == mctb_pkg::OP_TICK) begin
						t_d     = '0;
						state_d = mctb_pkg::B_TLOAD;
					end else begin
						state_d = mctb_pkg::B_STAT;
						if (q_data.idx_ok) begin
							case (q_data.op)
								mctb_pkg::OP_START: begin
									run_d[ci] = 1'b1;
									if (ph_q[ci] == mctb_pkg::PH_OFF) begin
										if (cst_nz && cval <= XW'(0))
											ph_d[ci] = (cval <= -ALERT_X) ?
												mctb_pkg::PH_STOPPED : mctb_pkg::PH_NEGATIVE;
										else
											ph_d[ci] = mctb_pkg::PH_RUNNING;
									end
								end
								mctb_pkg::OP_STOP: run_d[ci] = 1'b0;
								mctb_pkg::OP_LOAD_START, mctb_pkg::OP_LOAD_SET: begin
									run_d[ci] = 1'b0;
									ph_d[ci]  = mctb_pkg::PH_OFF;
									sub_d[ci] = '0;
									val_d[ci] = (q_data.op == mctb_pkg::OP_LOAD_SET) ?
										q_data.setv : $signed({1'b0, cfg.start[q_data.idx]});
								end
								default: ;
							endcase
						end
					end
				end
			end
			mctb_pkg::B_TLOAD: begin
				if (run_q[t_q]) begin
					sub_d[t_q] = mctb_pkg::SUB_W'(rem);
					secs_d     = secs_c;
				end
				if (run_q[t_q] && secs_c != '0) begin
					state_d = mctb_pkg::B_SEC;
				end else begin
					t_d     = t_next;
					state_d = s_next;
				end
			end
			mctb_pkg::B_SEC: begin
				if (out_free) begin
					if (brk) begin
						// saturated: drop the rest of this tick for the timer
						secs_d  = '0;
						t_d     = t_next;
						state_d = s_next;
					end else begin
						secs_d     = secs_q - 2'd1;
						ph_d[t_q]  = ph_n;
						val_d[t_q] = nval[VW-1:0];
						if (el_ev) begin
							ld          = 1'b1;
							evt_d.kind  = mctb_pkg::EV_ELAPSED;
							evt_d.value = mctb_pkg::sat_val(cst - nv);
						end else if (ph_n == mctb_pkg::PH_RUNNING && cfg.cd_beep[tsel] && !up) begin
							ld          = 1'b1;
							evt_d.kind  = mctb_pkg::EV_COUNTDOWN;
							evt_d.value = nval[VW-1:0];
						end
						ann_d   = ann_c;
						min_d   = (ph_n == mctb_pkg::PH_RUNNING) && cfg.min_beep[tsel];
						state_d = mctb_pkg::B_MIN;
					end
				end
			end
			mctb_pkg::B_MIN: begin
				if (out_free) begin
					if (min_q && mctb_pkg::is_minute(ann_q)) begin
						ld          = 1'b1;
						evt_d.kind  = mctb_pkg::EV_MINUTE;
						evt_d.value = mctb_pkg::sat_val(ann_q);
					end
					if (secs_q != '0) begin
						state_d = mctb_pkg::B_SEC;
					end else begin
						t_d     = t_next;
						state_d = s_next;
					end
				end
			end
			mctb_pkg::B_STAT: begin
				if (out_free) begin
					ld          = 1'b1;
					q_pop       = 1'b1;
					evt_d.kind  = mctb_pkg::EV_STATUS;
					evt_d.timer = q_data.idx;
					evt_d.last  = 1'b1;
					if (q_data.idx_ok) begin
						evt_d.value   = val_q[ci];
						evt_d.ph      = ph_q[ci];
						evt_d.running = run_q[ci];
					end
					state_d = mctb_pkg::B_IDLE;
				end
			end
			default: state_d = mctb_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mctb_pkg::B_IDLE;
			t_q     <= '0;
			secs_q  <= '0;
			min_q   <= 1'b0;
			ov_q    <= 1'b0;
			run_q   <= '0;
			for (int i = 0; i < TIMER_COUNT; i++) begin
				val_q[i] <= '0;
				sub_q[i] <= '0;
				ph_q[i]  <= mctb_pkg::PH_OFF;
			end
		end else begin
			state_q <= state_d;
			t_q     <= t_d;
			secs_q  <= secs_d;
			min_q   <= min_d;
			run_q   <= run_d;
			val_q   <= val_d;
			sub_q   <= sub_d;
			ph_q    <= ph_d;
			if (ld)
				ov_q <= 1'b1;
			else if (events.ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		ann_q <= ann_d;
		if (ld)
			evt_q <= evt_d;
	end

	assign events.valid         = ov_q;
	assign events.event_kind    = evt_q.kind;
	assign events.event_timer   = evt_q.timer;
	assign events.event_value   = evt_q.value;
	assign events.timer_phase   = evt_q.ph;
	assign events.timer_running = evt_q.running;
	assign events.last          = evt_q.last;

	a_pop_in_stat: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == mctb_pkg::B_STAT)
		else $error("queue popped outside status state");

	a_sec_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mctb_pkg::B_SEC |-> secs_q != '0)
		else $error("second step entered with no seconds left");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ld |-> out_free)
		else $error("event register overwritten while full");

endmodule

// File: bench/tb_multi_countdown_timer_bank_unit.sv
// Self-checking bench for multi_countdown_timer_bank_unit: command beats in,
// event beats out, registers over APB; a built-in timer bank model predicts events.
// Depends on mctb_pkg and the mctb_cmd_if / mctb_evt_if interfaces.
`timescale 1ns / 1ps
module tb_multi_countdown_timer_bank_unit;

	localparam int CMD_W   = mctb_pkg::CMD_W;
	localparam int IDX_W   = mctb_pkg::IDX_W;
	localparam int VAL_W   = mctb_pkg::VAL_W;
	localparam int SUB_W   = mctb_pkg::SUB_W;
	localparam int START_W = mctb_pkg::START_W;
	localparam int MASK_W  = mctb_pkg::MASK_W;
	localparam int TICK_W  = mctb_pkg::TICK_W;
	localparam int ADDR_W  = mctb_pkg::ADDR_W;
	localparam int DATA_W  = mctb_pkg::DATA_W;

	localparam int NUM_TIMERS = 3;
	localparam int ALERT_SECS = 60;
	localparam longint CYCLE_LIMIT = 2000000;
	localparam logic [CMD_W-1:0] CMD_BAD_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_BAD_7 = 3'd7;
	localparam logic [IDX_W-1:0] IDX_ABSENT = 2'd3;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata, prdata;

	mctb_cmd_if cmds ();
	mctb_evt_if events ();

	multi_countdown_timer_bank_unit dut (
		.clk(clk), .arst_n(arst_n), .cmds(cmds), .events(events),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// bank model state
	logic signed [VAL_W-1:0] tmr_val [NUM_TIMERS];
	logic [SUB_W-1:0]        tmr_sub [NUM_TIMERS];
	mctb_pkg::phase_t        tmr_ph  [NUM_TIMERS];
	logic                    tmr_run [NUM_TIMERS];
	logic [START_W-1:0]      start_secs [NUM_TIMERS];
	logic [MASK_W-1:0]       show_el_mask, cd_beep_mask, min_beep_mask;

	mctb_pkg::evt_t pending_events[$];
	int     mismatches = 0;
	longint cycles = 0;
	bit     idle_on = 1;
	bit     stall_req = 0;
	int     hold_left = 0;

	typedef struct {
		logic [CMD_W-1:0]        cmd;
		logic [IDX_W-1:0]        idx;
		logic signed [VAL_W-1:0] setv;
		logic [TICK_W-1:0]       tick;
		bit                      typed;
		logic signed [VAL_W-1:0] x_val;
		mctb_pkg::phase_t        x_ph;
		logic                    x_run;
	} step_row_t;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	task automatic log_event(input mctb_pkg::kind_t k, input int t, input longint v,
			input mctb_pkg::phase_t p, input logic r, input logic l);
		mctb_pkg::evt_t e;
		if (v > 8388607) v = 8388607;
		if (v < -8388608) v = -8388608;
		e.kind = k; e.timer = IDX_W'(t); e.value = v[VAL_W-1:0];
		e.ph = p; e.running = r; e.last = l;
		pending_events.push_back(e);
	endtask

	task automatic step_timer(input int i, input int tick);
		longint st, val, nv, ann;
		int total, secs;
		st = start_secs[i];
		total = tmr_sub[i] + tick;
		secs = total / 100;
		tmr_sub[i] = SUB_W'(total % 100);
		while (secs > 0) begin
			val = tmr_val[i];
			secs--;
			if ((st == 0 && val >= 8388607) || (st != 0 && val <= -8388608))
				break;
			nv = (st != 0 ? st - val : val) + 1;
			if (tmr_ph[i] == mctb_pkg::PH_RUNNING) begin
				if (st != 0 && nv >= st) begin
					tmr_ph[i] = mctb_pkg::PH_NEGATIVE;
					log_event(mctb_pkg::EV_ELAPSED, i, st - nv, mctb_pkg::PH_OFF, 0, 0);
				end
			end else if (tmr_ph[i] == mctb_pkg::PH_NEGATIVE) begin
				if (nv >= st + ALERT_SECS)
					tmr_ph[i] = mctb_pkg::PH_STOPPED;
			end
			if (st != 0)
				nv = st - nv;
			tmr_val[i] = nv[VAL_W-1:0];
			if (tmr_ph[i] == mctb_pkg::PH_RUNNING) begin
				ann = nv;
				if (cd_beep_mask[i] && st != 0)
					log_event(mctb_pkg::EV_COUNTDOWN, i, nv, mctb_pkg::PH_OFF, 0, 0);
				if (show_el_mask[i])
					ann = st - nv;
				if (min_beep_mask[i] && (ann % 60) == 0)
					log_event(mctb_pkg::EV_MINUTE, i, ann, mctb_pkg::PH_OFF, 0, 0);
			end
		end
	endtask

	task automatic advance_bank(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
			input logic signed [VAL_W-1:0] setv, input logic [TICK_W-1:0] tick);
		bit present;
		present = idx < NUM_TIMERS;
		if (cmd == mctb_pkg::CMD_TICK) begin
			for (int i = 0; i < NUM_TIMERS; i++)
				if (tmr_run[i])
					step_timer(i, tick);
		end else if (present && cmd == mctb_pkg::CMD_START) begin
			tmr_run[idx] = 1;
			if (tmr_ph[idx] == mctb_pkg::PH_OFF) begin
				if (start_secs[idx] != 0 && tmr_val[idx] <= 0)
					tmr_ph[idx] = (tmr_val[idx] <= -ALERT_SECS) ?
						mctb_pkg::PH_STOPPED : mctb_pkg::PH_NEGATIVE;
				else
					tmr_ph[idx] = mctb_pkg::PH_RUNNING;
			end
		end else if (present && cmd == mctb_pkg::CMD_STOP) begin
			tmr_run[idx] = 0;
		end else if (present && (cmd == mctb_pkg::CMD_RESET || cmd == mctb_pkg::CMD_SET)) begin
			tmr_run[idx] = 0;
			tmr_ph[idx] = mctb_pkg::PH_OFF;
			tmr_sub[idx] = '0;
			tmr_val[idx] = (cmd == mctb_pkg::CMD_RESET) ? VAL_W'(start_secs[idx]) : setv;
		end
		if (present)
			log_event(mctb_pkg::EV_STATUS, idx, tmr_val[idx], tmr_ph[idx], tmr_run[idx], 1);
		else
			log_event(mctb_pkg::EV_STATUS, idx, 0, mctb_pkg::PH_OFF, 0, 1);
	endtask

	// check every event beat against the oldest prediction
	always @(posedge clk) begin
		mctb_pkg::evt_t x;
		if (arst_n && events.valid && events.ready) begin
			if (pending_events.size() == 0) begin
				flag_mismatch($sformatf("unexpected beat kind %0d timer %0d value %0d",
					events.event_kind, events.event_timer, events.event_value));
			end else begin
				x = pending_events.pop_front();
				if (events.event_kind !== x.kind || events.event_timer !== x.timer ||
						events.event_value !== x.value || events.timer_phase !== x.ph ||
						events.timer_running !== x.running || events.last !== x.last)
					flag_mismatch($sformatf(
						"got k%0d t%0d v%0d p%0d r%0d l%0d, want k%0d t%0d v%0d p%0d r%0d l%0d",
						events.event_kind, events.event_timer, events.event_value,
						events.timer_phase, events.timer_running, events.last,
						x.kind, x.timer, x.value, x.ph, x.running, x.last));
			end
		end
	end

	// receiver side: random back-pressure, plus one long hold-off on request
	initial begin
		events.ready = 0;
		forever begin
			@(posedge clk);
			if (stall_req) begin
				stall_req = 0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				events.ready <= 0;
			end else begin
				events.ready <= !(idle_on && $urandom_range(99) < 8);
			end
		end
	end

	task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
			input logic signed [VAL_W-1:0] setv, input logic [TICK_W-1:0] tick);
		while (idle_on && $urandom_range(99) < 8) begin
			cmds.valid <= 0;
			@(posedge clk);
		end
		cmds.valid <= 1;
		cmds.cmd <= cmd;
		cmds.timer_index <= idx;
		cmds.set_value <= setv;
		cmds.tick_10ms <= tick;
		@(posedge clk);
		while (!cmds.ready) @(posedge clk);
		advance_bank(cmd, idx, setv, tick);
	endtask

	task automatic drain();
		cmds.valid <= 0;
		while (pending_events.size() != 0) @(posedge clk);
		// leave a quiet gap before the next register write
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(input mctb_pkg::reg_t r, input logic [DATA_W-1:0] data);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= ADDR_W'(4 * int'(r)); pwdata <= data;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (r)
			mctb_pkg::REG_START_0, mctb_pkg::REG_START_1, mctb_pkg::REG_START_2:
				start_secs[int'(r)] = data[START_W-1:0];
			mctb_pkg::REG_SHOW_EL: show_el_mask = data[MASK_W-1:0];
			mctb_pkg::REG_CD_BEEP: cd_beep_mask = data[MASK_W-1:0];
			default: min_beep_mask = data[MASK_W-1:0];
		endcase
	endtask

	task automatic set_bank(input int s0, input int s1, input int s2, input int se,
			input int cd, input int mn);
		write_reg(mctb_pkg::REG_START_0, s0);
		write_reg(mctb_pkg::REG_START_1, s1);
		write_reg(mctb_pkg::REG_START_2, s2);
		write_reg(mctb_pkg::REG_SHOW_EL, se);
		write_reg(mctb_pkg::REG_CD_BEEP, cd);
		write_reg(mctb_pkg::REG_MIN_BEEP, mn);
	endtask

	function automatic logic signed [VAL_W-1:0] pick_value();
		int sel;
		sel = $urandom_range(99);
		if (sel < 50) return VAL_W'($urandom_range(200) - 70);
		if (sel < 65) return VAL_W'(60 * $urandom_range(10) - $urandom_range(3));
		if (sel < 75) return mctb_pkg::VAL_MAX - VAL_W'($urandom_range(4));
		if (sel < 85) return mctb_pkg::VAL_MIN + VAL_W'($urandom_range(4));
		return VAL_W'($urandom);
	endfunction

	task automatic random_beats(input int count);
		int sel;
		logic [CMD_W-1:0] c;
		logic [IDX_W-1:0] ix;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(99);
			if (sel < 45) c = mctb_pkg::CMD_TICK;
			else if (sel < 60) c = mctb_pkg::CMD_START;
			else if (sel < 66) c = mctb_pkg::CMD_STOP;
			else if (sel < 74) c = mctb_pkg::CMD_RESET;
			else if (sel < 86) c = mctb_pkg::CMD_SET;
			else if (sel < 96) c = mctb_pkg::CMD_READ;
			else c = $urandom_range(1) ? CMD_BAD_6 : CMD_BAD_7;
			ix = ($urandom_range(19) == 0) ? IDX_ABSENT : IDX_W'($urandom_range(2));
			send_beat(c, ix, pick_value(), TICK_W'($urandom));
		end
	endtask

	step_row_t plan [$];

	function automatic step_row_t row(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] ix,
			input int sv, input int tk, input bit typed = 0, input int xv = 0,
			input mctb_pkg::phase_t xp = mctb_pkg::PH_OFF, input logic xr = 0);
		step_row_t r;
		r.cmd = c; r.idx = ix; r.setv = VAL_W'(sv); r.tick = TICK_W'(tk);
		r.typed = typed; r.x_val = VAL_W'(xv); r.x_ph = xp; r.x_run = xr;
		return r;
	endfunction

	initial begin
		mctb_pkg::evt_t got;
		arst_n = 0;
		cmds.valid = 0; cmds.cmd = mctb_pkg::CMD_TICK; cmds.timer_index = '0;
		cmds.set_value = '0; cmds.tick_10ms = '0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			tmr_val[i] = '0; tmr_sub[i] = '0; tmr_ph[i] = mctb_pkg::PH_OFF; tmr_run[i] = 0;
			start_secs[i] = '0;
		end
		show_el_mask = '0; cd_beep_mask = '0; min_beep_mask = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		repeat (3) @(posedge clk);

		plan.push_back(row(mctb_pkg::CMD_READ, 0, 0, 0, 1, 0, mctb_pkg::PH_OFF, 0));
		plan.push_back(row(mctb_pkg::CMD_READ, IDX_ABSENT, 0, 0, 1, 0, mctb_pkg::PH_OFF, 0));
		drain();
		set_bank(5, 0, 8388607, 3'b010, 3'b111, 3'b111);
		plan.push_back(row(mctb_pkg::CMD_RESET, 0, 0, 0, 1, 5, mctb_pkg::PH_OFF, 0));
		plan.push_back(row(mctb_pkg::CMD_START, 0, 0, 0, 1, 5, mctb_pkg::PH_RUNNING, 1));
		plan.push_back(row(mctb_pkg::CMD_TICK, 0, 0, 255));
		plan.push_back(row(mctb_pkg::CMD_TICK, 0, 0, 255));
		plan.push_back(row(mctb_pkg::CMD_TICK, 0, 0, 0));
		plan.push_back(row(CMD_BAD_6, 1, 0, 0, 1, 0, mctb_pkg::PH_OFF, 0));
		plan.push_back(row(CMD_BAD_7, 1, 0, 0, 1, 0, mctb_pkg::PH_OFF, 0));
		plan.push_back(row(mctb_pkg::CMD_SET, 1, 59, 0, 1, 59, mctb_pkg::PH_OFF, 0));
		plan.push_back(row(mctb_pkg::CMD_START, 1, 0, 0, 1, 59, mctb_pkg::PH_RUNNING, 1));
		plan.push_back(row(mctb_pkg::CMD_TICK, 3, 0, 100));
		plan.push_back(row(mctb_pkg::CMD_SET, 2, -8388608, 0, 1, -8388608,
			mctb_pkg::PH_OFF, 0));
		plan.push_back(row(mctb_pkg::CMD_START, 2, 0, 0, 1, -8388608,
			mctb_pkg::PH_STOPPED, 1));
		plan.push_back(row(mctb_pkg::CMD_TICK, 0, 0, 200));
		plan.push_back(row(mctb_pkg::CMD_SET, 1, 8388606, 0, 1, 8388606,
			mctb_pkg::PH_OFF, 0));
		plan.push_back(row(mctb_pkg::CMD_START, 1, 0, 0, 1, 8388606,
			mctb_pkg::PH_RUNNING, 1));
		plan.push_back(row(mctb_pkg::CMD_TICK, 0, 0, 255));
		plan.push_back(row(mctb_pkg::CMD_SET, 0, 0, 0, 1, 0, mctb_pkg::PH_OFF, 0));
		plan.push_back(row(mctb_pkg::CMD_START, 0, 0, 0, 1, 0, mctb_pkg::PH_NEGATIVE, 1));
		plan.push_back(row(mctb_pkg::CMD_SET, 0, -60, 0, 1, -60, mctb_pkg::PH_OFF, 0));
		plan.push_back(row(mctb_pkg::CMD_START, 0, 0, 0, 1, -60, mctb_pkg::PH_STOPPED, 1));
		plan.push_back(row(mctb_pkg::CMD_STOP, 0, 0, 0, 1, -60, mctb_pkg::PH_STOPPED, 0));
		plan.push_back(row(mctb_pkg::CMD_SET, 2, 8388607, 7, 1, 8388607,
			mctb_pkg::PH_OFF, 0));
		plan.push_back(row(mctb_pkg::CMD_STOP, IDX_ABSENT, 0, 0, 1, 0, mctb_pkg::PH_OFF, 0));
		foreach (plan[k]) begin
			if (k == 2) drain();
			send_beat(plan[k].cmd, plan[k].idx, plan[k].setv, plan[k].tick);
			got = pending_events[$];
			if (plan[k].typed && (got.value !== plan[k].x_val || got.ph !== plan[k].x_ph ||
					got.running !== plan[k].x_run))
				flag_mismatch($sformatf("table row %0d disagrees with bank model", k));
		end
		drain();

		// extremes: longest and shortest countdowns, every event source on
		set_bank(8388607, 1, 60, 3'b111, 3'b111, 3'b111);
		random_beats(90);
		drain();

		// short countdowns and one count-up timer, no idling on either side
		idle_on = 0;
		set_bank(2, 0, 3, 3'b101, 3'b011, 3'b110);
		random_beats(90);
		drain();
		idle_on = 1;

		// all count up; long receiver hold-off fills the block
		set_bank(0, 0, 0, 3'b000, 3'b000, 3'b111);
		stall_req = 1;
		random_beats(90);
		drain();

		for (int p = 0; p < 2; p++) begin
			set_bank($urandom_range(120), $urandom_range(1) ? 0 : $urandom_range(8388607),
				$urandom_range(70), $urandom_range(7), $urandom_range(7), $urandom_range(7));
			random_beats(90);
			drain();
		end

		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending_events.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
